@@ hdl/isrt_pkg.sv @@
`default_nettype none
package isrt_pkg;

   localparam int VAL_W   = 31;   // range bound width, two's complement
   localparam int TOTAL_W = 32;   // element count width
   localparam int USED_W  = 7;    // reported range count width
   localparam int ENTRY_W = 2 * VAL_W;

   typedef enum logic {
      OP_INCLUDE = 1'b0,
      OP_EXCLUDE = 1'b1
   } op_type;

endpackage
`default_nettype wire

@@ hdl/isrt_req_if.sv @@
`default_nettype none
interface isrt_req_if import isrt_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    op;
   logic signed [VAL_W-1:0] range_low;
   logic signed [VAL_W-1:0] range_high;

   modport source (output valid, op, range_low, range_high, input ready);
   modport sink   (input valid, op, range_low, range_high, output ready);
endinterface
`default_nettype wire

@@ hdl/isrt_rsp_if.sv @@
`default_nettype none
interface isrt_rsp_if import isrt_pkg::*;;
   logic               valid;
   logic               ready;
   logic               changed;
   logic [TOTAL_W-1:0] element_total;
   logic [USED_W-1:0]  ranges_used;
   logic               table_full;

   modport source (output valid, changed, element_total, ranges_used, table_full,
                   input ready);
   modport sink   (input valid, changed, element_total, ranges_used, table_full,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/interval_set_range_table_core.sv @@
`default_nettype none
// channel  dir  beat contents                                          handshake
// req_bus  in   op, range_low, range_high                              valid/ready
// rsp_bus  out  changed, element_total, ranges_used, table_full       valid/ready
//
// One operation at a time, in steps: accept, scan the n stored ranges, plan,
// tail move when t entries move, piece writes (p = 0..2 new pieces), result.
// An exclude that misses or a refused beat skips move and pieces; an empty range
// skips scan and plan as well and goes straight to the result.
// Synchronous reset empties the set (count registers only, the RAM is never cleared).
// A result waits in the rsp register; the next req beat is taken meanwhile.
module interval_set_range_table_core import isrt_pkg::*; #(
   parameter int MAX_RANGES = 64,
   localparam int CNT_W  = $clog2(MAX_RANGES + 1),
   localparam int ADDR_W = $clog2(MAX_RANGES)
) (
   input wire logic    clock,
   input wire logic    reset,
   isrt_req_if.sink    req_bus,
   isrt_rsp_if.source  rsp_bus
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,   // read all entries, locate the touched run
      ST_PLAN  = 6'b000100,   // build new pieces, check for overflow
      ST_SHIFT = 6'b001000,   // move the tail up or down
      ST_PIECE = 6'b010000,   // write the new pieces
      ST_DONE  = 6'b100000
   } state_type;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   state_type state_ff, state_in;

   logic                    op_ff, op_in;
   logic signed [VAL_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;

   logic [CNT_W-1:0]        rd_ff, rd_in, rem_ff, rem_in, wa_ff, wa_in, gap_ff, gap_in;
   logic                    dvld_ff, dvld_in, up_ff, up_in;
   logic [CNT_W-1:0]        pos_ff, pos_in, m_ff, m_in;   // first touched index, run length
   logic signed [VAL_W-1:0] si_ff, si_in, ej_ff, ej_in;
   logic [32:0]             old_ff, old_in;               // elements in the touched run
   logic [1:0]              p_ff, p_in, pw_ff, pw_in;
   logic signed [VAL_W-1:0] ps_ff [2], ps_in [2], pe_ff [2], pe_in [2];
   logic                    changed_ff, changed_in, full_ff, full_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_changed_ff, rsp_changed_in, rsp_full_ff, rsp_full_in;
   logic [TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]        rsp_used_ff, rsp_used_in;

   // table RAM, one entry = {start, end}
   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   isrt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // scan compare values, 33-bit signed so lo-1 and hi+1 never wrap
   logic signed [32:0] lo_x, hi_x, lo_t, hi_t, es_x, ee_x, si_x, ej_x;
   logic signed [32:0] p0s, p0e, nw, gain, kept;
   logic               below, overlap, ovl, left, right;
   logic [1:0]         p_new;
   logic [CNT_W-1:0]   tail, n_new;

   always_comb begin
      lo_x = 33'(lo_ff);
      hi_x = 33'(hi_ff);
      es_x = 33'($signed(ram_rd_data[ENTRY_W-1:VAL_W]));
      ee_x = 33'($signed(ram_rd_data[VAL_W-1:0]));
      si_x = 33'(si_ff);
      ej_x = 33'(ej_ff);
      // include also absorbs ranges that only touch
      lo_t = (op_ff == OP_INCLUDE) ? lo_x - 33'sd1 : lo_x;
      hi_t = (op_ff == OP_INCLUDE) ? hi_x + 33'sd1 : hi_x;
      below   = ee_x < lo_t;
      overlap = !below && (es_x <= hi_t);

      ovl   = (m_ff != '0);
      left  = ovl && (si_x < lo_x);
      right = ovl && (ej_x > hi_x);
      p0s   = left  ? si_x : lo_x;
      p0e   = right ? ej_x : hi_x;
      nw    = p0e - p0s + 33'sd1;
      gain  = nw - $signed(old_ff);
      kept  = (left ? lo_x - si_x : 33'sd0) + (right ? ej_x - hi_x : 33'sd0);
      p_new = (op_ff == OP_INCLUDE) ? 2'd1 : {1'b0, left} + {1'b0, right};
      n_new = n_ff - m_ff + CNT_W'(p_new);
      tail  = n_ff - (pos_ff + m_ff);
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      n_in       = n_ff;
      total_in   = total_ff;
      rd_in      = rd_ff;
      rem_in     = rem_ff;
      wa_in      = wa_ff;
      gap_in     = gap_ff;
      dvld_in    = 1'b0;
      up_in      = up_ff;
      pos_in     = pos_ff;
      m_in       = m_ff;
      si_in      = si_ff;
      ej_in      = ej_ff;
      old_in     = old_ff;
      p_in       = p_ff;
      pw_in      = pw_ff;
      ps_in      = ps_ff;
      pe_in      = pe_ff;
      changed_in = changed_ff;
      full_in    = full_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_ff[ADDR_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = wa_ff[ADDR_W-1:0];
      ram_wr_data = ram_rd_data;

      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_changed_in = rsp_changed_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_used_in    = rsp_used_ff;

      req_bus.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in      = req_bus.op;
               lo_in      = req_bus.range_low;
               hi_in      = req_bus.range_high;
               rd_in      = '0;
               pos_in     = '0;
               m_in       = '0;
               old_in     = '0;
               changed_in = 1'b0;
               full_in    = 1'b0;
               // empty range: ignored
               state_in   = (req_bus.range_low > req_bus.range_high) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_ff < n_ff) begin
               ram_rd_en = 1'b1;
               rd_in     = rd_ff + ONE;
               dvld_in   = 1'b1;
            end
            if (dvld_ff) begin
               if (below) begin
                  pos_in = pos_ff + ONE;
               end else if (overlap) begin
                  if (m_ff == '0) begin
                     si_in = ram_rd_data[ENTRY_W-1:VAL_W];
                  end
                  ej_in  = ram_rd_data[VAL_W-1:0];
                  m_in   = m_ff + ONE;
                  old_in = old_ff + 33'(ee_x - es_x + 33'sd1);
               end
            end
            if (!(rd_ff < n_ff) && !dvld_ff) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            p_in     = p_new;
            pw_in    = '0;
            ps_in[0] = (op_ff == OP_INCLUDE) ? VAL_W'(p0s) : (left ? si_ff : hi_ff + 1'b1);
            pe_in[0] = (op_ff == OP_INCLUDE) ? VAL_W'(p0e) : (left ? lo_ff - 1'b1 : ej_ff);
            ps_in[1] = hi_ff + 1'b1;
            pe_in[1] = ej_ff;
            if (op_ff == OP_EXCLUDE && !ovl) begin
               state_in = ST_DONE;
            end else if (CNT_W'(p_new) > m_ff && n_ff == MAX_CNT) begin
               full_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               changed_in = (op_ff == OP_EXCLUDE) || (gain != 33'sd0);
               total_in   = (op_ff == OP_INCLUDE) ? total_ff + TOTAL_W'(gain)
                                                  : total_ff - TOTAL_W'($signed(old_ff) - kept);
               n_in       = n_new;
               rem_in     = tail;
               up_in      = CNT_W'(p_new) > m_ff;
               gap_in     = m_ff - CNT_W'(p_new);
               rd_in      = (CNT_W'(p_new) > m_ff) ? n_ff - ONE : pos_ff + m_ff;
               state_in   = (CNT_W'(p_new) == m_ff || tail == '0) ? ST_PIECE : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // up: walk down from the top; down: walk up, both never hit unread data
            if (rem_ff != '0) begin
               ram_rd_en = 1'b1;
               rem_in    = rem_ff - ONE;
               rd_in     = up_ff ? rd_ff - ONE : rd_ff + ONE;
               wa_in     = up_ff ? rd_ff + ONE : rd_ff - gap_ff;
               dvld_in   = 1'b1;
            end
            if (dvld_ff) begin
               ram_wr_en = 1'b1;
            end
            if (rem_ff == '0 && !dvld_ff) begin
               state_in = ST_PIECE;
            end
         end
         ST_PIECE: begin
            if (pw_ff < p_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ADDR_W'(pos_ff + CNT_W'(pw_ff));
               ram_wr_data = {ps_ff[pw_ff[0]], pe_ff[pw_ff[0]]};
               pw_in       = pw_ff + 2'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_changed_in = changed_ff;
               rsp_full_in    = full_ff;
               rsp_total_in   = total_ff;
               rsp_used_in    = n_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         total_ff     <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         total_ff     <= total_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      rd_ff          <= rd_in;
      rem_ff         <= rem_in;
      wa_ff          <= wa_in;
      gap_ff         <= gap_in;
      up_ff          <= up_in;
      pos_ff         <= pos_in;
      m_ff           <= m_in;
      si_ff          <= si_in;
      ej_ff          <= ej_in;
      old_ff         <= old_in;
      p_ff           <= p_in;
      pw_ff          <= pw_in;
      ps_ff          <= ps_in;
      pe_ff          <= pe_in;
      changed_ff     <= changed_in;
      full_ff        <= full_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.changed       = rsp_changed_ff;
   assign rsp_bus.element_total = rsp_total_ff;
   assign rsp_bus.ranges_used   = USED_W'(rsp_used_ff);
   assign rsp_bus.table_full    = rsp_full_ff;

endmodule
`default_nettype wire

@@ hdl/isrt_ram.sv @@
`default_nettype none
module isrt_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
